### sv/rtbn_pkg.sv
package rtbn_pkg;

  // fixed field widths
  localparam int CfgBits    = 32;
  localparam int CfgIdxBits = 2;
  localparam int RowBits    = 16;
  localparam int ByteBits   = 8;
  localparam int ByteMax    = 255;
  localparam int PadBits    = 2;

  // one quotient bit per divider step
  localparam int DivSteps   = ByteBits;
  localparam int StepBits   = $clog2(DivSteps);

  // parameter defaults
  localparam int DefValueBits  = 32;
  localparam int DefColumnBits = 16;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_RANGE_MIN = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_RANGE_MAX = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_ROW_WIDTH = 2'd2;

  // reset values of the configuration registers
  localparam logic [CfgBits-1:0] RangeMinReset = 32'd0;
  localparam logic [CfgBits-1:0] RangeMaxReset = 32'd255;
  localparam logic [RowBits-1:0] RowWidthReset = 16'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SETUP,
    ST_DIV,
    ST_EMIT
  } state_t;

  // strobes from the sequencer to the datapath and divider
  typedef struct packed {
    logic capture;
    logic clamp;
    logic load;
    logic step;
  } seq_ctl_t;

endpackage

### sv/rtbn_div.sv
// shared shift-subtract divider, one quotient bit per step
module rtbn_div #(
  parameter int NUM_BITS = rtbn_pkg::DefValueBits + 9
) (
  input  logic                          clk,
  input  rtbn_pkg::seq_ctl_t            ctl,
  input  logic [NUM_BITS-1:0]           num,
  input  logic [NUM_BITS-1:0]           den,
  output logic [rtbn_pkg::ByteBits-1:0] quot
);

  logic [NUM_BITS-1:0]           rem_r, rem_nxt;
  logic [NUM_BITS-1:0]           den_r, den_nxt;
  logic [rtbn_pkg::ByteBits-1:0] quot_r, quot_nxt;
  logic                          fits;

  // trial subtract of the shifted divisor
  assign fits = (rem_r >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (ctl.load) begin
      rem_nxt  = num;
      den_nxt  = den << (rtbn_pkg::DivSteps - 1);
      quot_nxt = '0;
    end else if (ctl.step) begin
      if (fits) begin
        rem_nxt = rem_r - den_r;
      end
      den_nxt  = den_r >> 1;
      quot_nxt = {quot_r[rtbn_pkg::ByteBits-2:0], fits};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule

### sv/rtbn_seq.sv
// sequencer, column counter and result word output
module rtbn_seq #(
  parameter int COLUMN_BITS = rtbn_pkg::DefColumnBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rtbn_pkg::ByteBits-1:0] out_byte,
  output logic                          out_is_padding,
  output logic                          out_last_of_run,
  input  logic [rtbn_pkg::RowBits-1:0]  row_width,
  input  logic [rtbn_pkg::ByteBits-1:0] pix_byte,
  output rtbn_pkg::seq_ctl_t            ctl
);

  localparam int CmpBits = (COLUMN_BITS + 1 > rtbn_pkg::RowBits) ?
                           COLUMN_BITS + 1 : rtbn_pkg::RowBits;

  rtbn_pkg::state_t state_r, state_nxt;

  logic [rtbn_pkg::StepBits-1:0] step_r, step_nxt;
  logic [COLUMN_BITS-1:0]        col_r, col_nxt;
  logic [rtbn_pkg::PadBits-1:0]  pad_cnt_r, pad_cnt_nxt;
  logic [rtbn_pkg::PadBits-1:0]  pad_idx_r, pad_idx_nxt;

  logic                         accept;
  logic                         taken;
  logic                         last_word;
  logic [rtbn_pkg::RowBits-1:0] eff_width;
  logic [CmpBits-1:0]           col_next;
  logic                         row_end;

  assign accept    = in_valid && !in_stall;
  assign taken     = out_valid && !out_stall;
  assign last_word = (pad_idx_r == pad_cnt_r);

  // row width zero behaves as one
  assign eff_width = (row_width == '0) ? rtbn_pkg::RowBits'(1) : row_width;
  assign col_next  = CmpBits'(col_r) + CmpBits'(1);
  assign row_end   = (col_next >= CmpBits'(eff_width));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtbn_pkg::ST_IDLE:  if (in_valid) state_nxt = rtbn_pkg::ST_CLAMP;
      rtbn_pkg::ST_CLAMP: state_nxt = rtbn_pkg::ST_SETUP;
      rtbn_pkg::ST_SETUP: state_nxt = rtbn_pkg::ST_DIV;
      rtbn_pkg::ST_DIV: begin
        if (step_r == rtbn_pkg::StepBits'(rtbn_pkg::DivSteps - 1)) begin
          state_nxt = rtbn_pkg::ST_EMIT;
        end
      end
      rtbn_pkg::ST_EMIT: if (taken && last_word) state_nxt = rtbn_pkg::ST_IDLE;
      default: state_nxt = rtbn_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl             = '0;
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    out_byte        = '0;
    out_is_padding  = 1'b0;
    out_last_of_run = 1'b0;
    case (state_r)
      rtbn_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      rtbn_pkg::ST_CLAMP: ctl.clamp = 1'b1;
      rtbn_pkg::ST_SETUP: ctl.load  = 1'b1;
      rtbn_pkg::ST_DIV:   ctl.step  = 1'b1;
      rtbn_pkg::ST_EMIT: begin
        out_valid       = 1'b1;
        out_is_padding  = (pad_idx_r != '0);
        out_byte        = (pad_idx_r == '0) ? pix_byte : '0;
        out_last_of_run = last_word;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // counters: divider steps, column position, padding words
  always_comb begin
    step_nxt    = step_r;
    col_nxt     = col_r;
    pad_cnt_nxt = pad_cnt_r;
    pad_idx_nxt = pad_idx_r;
    if (accept) begin
      pad_idx_nxt = '0;
      if (row_end) begin
        col_nxt     = '0;
        pad_cnt_nxt = rtbn_pkg::PadBits'(
                        {rtbn_pkg::PadBits{1'b0}} - eff_width[rtbn_pkg::PadBits-1:0]);
      end else begin
        col_nxt     = col_next[COLUMN_BITS-1:0];
        pad_cnt_nxt = '0;
      end
    end
    if (ctl.load) begin
      step_nxt = '0;
    end else if (ctl.step) begin
      step_nxt = step_r + rtbn_pkg::StepBits'(1);
    end
    if (taken && !last_word) begin
      pad_idx_nxt = pad_idx_r + rtbn_pkg::PadBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rtbn_pkg::ST_IDLE;
      col_r     <= '0;
      step_r    <= '0;
      pad_cnt_r <= '0;
      pad_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      step_r    <= step_nxt;
      pad_cnt_r <= pad_cnt_nxt;
      pad_idx_r <= pad_idx_nxt;
    end
  end

  // the divider runs exactly its step count before the first word
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtbn_pkg::ST_DIV) &&
    (step_r == rtbn_pkg::StepBits'(rtbn_pkg::DivSteps - 1))
    |=> out_valid && !out_is_padding)
    else $error("divider did not hand over after its last step");

  // the padding index never passes the padding count
  a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pad_idx_r <= pad_cnt_r)
    else $error("padding index beyond padding count");

  // the last word of a run frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    taken && out_last_of_run |=> !in_stall && !out_valid)
    else $error("block still busy after the last word");

  // an accepted word starts the clamp cycle
  a_accept_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctl.clamp && in_stall)
    else $error("accepted word did not start processing");

endmodule

### sv/range_to_byte_normalizer.sv
// channel | ports                                  | direction
// --------+----------------------------------------+----------
// in      | in_valid, in_stall, in_pixel_value     | sink
// out     | out_valid, out_stall, out_byte,        | source
//         | out_is_padding, out_last_of_run        |
// cfg     | cfg_we, cfg_idx, cfg_wdata             | sink
//
// one pixel word passes accept, clamp, setup and eight steps of the
// shared shift-subtract divider, one quotient bit each, on its way to its byte.
// the pixel byte and up to three padding words follow, one per cycle
// unless out_stall holds them; in_stall stays high until the last is taken.
// rst_n is synchronous: registers return to min 0, max 255, width 4 and
// the column counter to zero. no clearing pass is needed.
module range_to_byte_normalizer #(
  parameter int VALUE_BITS  = rtbn_pkg::DefValueBits,
  parameter int COLUMN_BITS = rtbn_pkg::DefColumnBits
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [VALUE_BITS-1:0]           in_pixel_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rtbn_pkg::ByteBits-1:0]   out_byte,
  output logic                            out_is_padding,
  output logic                            out_last_of_run,
  input  logic                            cfg_we,
  input  logic [rtbn_pkg::CfgIdxBits-1:0] cfg_idx,
  input  logic [rtbn_pkg::CfgBits-1:0]    cfg_wdata
);

  localparam int NumBits = VALUE_BITS + 9;

  logic [rtbn_pkg::CfgBits-1:0] range_min_r;
  logic [rtbn_pkg::CfgBits-1:0] range_max_r;
  logic [rtbn_pkg::RowBits-1:0] row_width_r;

  logic signed [VALUE_BITS-1:0] lo_s, hi_s, clamped;
  logic signed [VALUE_BITS-1:0] pix_r, v_r;
  logic [VALUE_BITS-1:0]        span_r, d;
  logic                         ok_r;
  logic [NumBits-1:0]           num, den, d_ext, span_ext;
  logic [rtbn_pkg::ByteBits-1:0] quot, pix_byte;

  rtbn_pkg::seq_ctl_t ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= rtbn_pkg::RangeMinReset;
      range_max_r <= rtbn_pkg::RangeMaxReset;
      row_width_r <= rtbn_pkg::RowWidthReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        rtbn_pkg::CFG_RANGE_MIN: range_min_r <= cfg_wdata;
        rtbn_pkg::CFG_RANGE_MAX: range_max_r <= cfg_wdata;
        rtbn_pkg::CFG_ROW_WIDTH: row_width_r <= cfg_wdata[rtbn_pkg::RowBits-1:0];
        default: ;
      endcase
    end
  end

  // range limits read at the sample width
  if (VALUE_BITS <= rtbn_pkg::CfgBits) begin : g_narrow
    assign lo_s = range_min_r[VALUE_BITS-1:0];
    assign hi_s = range_max_r[VALUE_BITS-1:0];
  end else begin : g_wide
    assign lo_s = VALUE_BITS'(range_min_r);
    assign hi_s = VALUE_BITS'(range_max_r);
  end

  // clamp to the range
  assign clamped = (pix_r < lo_s) ? lo_s : ((hi_s < pix_r) ? hi_s : pix_r);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pix_r <= in_pixel_value;
    end
    if (ctl.clamp) begin
      v_r    <= clamped;
      span_r <= VALUE_BITS'(hi_s - lo_s);
      ok_r   <= (lo_s < hi_s);
    end
  end

  // dividend and divisor for the truncating or the rounded mapping
  assign d        = VALUE_BITS'(v_r - lo_s);
  assign d_ext    = NumBits'(d);
  assign span_ext = NumBits'(span_r);

  always_comb begin
    if (span_r > VALUE_BITS'(rtbn_pkg::ByteMax)) begin
      num = d_ext << 8;
      den = span_ext + NumBits'(1);
    end else begin
      num = (d_ext << 9) - (d_ext << 1) + span_ext;
      den = span_ext << 1;
    end
  end

  rtbn_div #(
    .NUM_BITS(NumBits)
  ) u_div (
    .clk  (clk),
    .ctl  (ctl),
    .num  (num),
    .den  (den),
    .quot (quot)
  );

  // empty or inverted range gives zero
  assign pix_byte = ok_r ? quot : '0;

  rtbn_seq #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_padding  (out_is_padding),
    .out_last_of_run (out_last_of_run),
    .row_width       (row_width_r),
    .pix_byte        (pix_byte),
    .ctl             (ctl)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int PixBits = rtbn_pkg::DefValueBits;
  // unmapped index, writes are dropped
  localparam logic [rtbn_pkg::CfgIdxBits-1:0] CFG_SPARE = 2'd3;
  localparam logic [PixBits-1:0] PixMin = {1'b1, {(PixBits-1){1'b0}}};
  localparam logic [PixBits-1:0] PixMax = {1'b0, {(PixBits-1){1'b1}}};
  localparam int HoldCycles = 300;
  localparam int PhaseWords = 24;
  localparam int RandPhases = 16;

  typedef struct packed {
    logic [rtbn_pkg::ByteBits-1:0] grey;
    logic                          pad;
    logic                          last;
  } out_word_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [PixBits-1:0]              in_pixel_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [rtbn_pkg::ByteBits-1:0]   out_byte;
  logic                            out_is_padding;
  logic                            out_last_of_run;
  logic                            cfg_we = 1'b0;
  logic [rtbn_pkg::CfgIdxBits-1:0] cfg_idx = rtbn_pkg::CFG_RANGE_MIN;
  logic [rtbn_pkg::CfgBits-1:0]    cfg_wdata = '0;

  // shadow of the block's registers and column position
  logic signed [rtbn_pkg::CfgBits-1:0] range_lo = rtbn_pkg::RangeMinReset;
  logic signed [rtbn_pkg::CfgBits-1:0] range_hi = rtbn_pkg::RangeMaxReset;
  logic [rtbn_pkg::RowBits-1:0]        row_width_q = rtbn_pkg::RowWidthReset;
  int unsigned                         cols_taken = 0;

  logic [PixBits-1:0] pixel_q[$];
  out_word_t          grey_words_due[$];

  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;
  int  errors = 0;
  logic in_fire = 1'b0;

  range_to_byte_normalizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_padding  (out_is_padding),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // grey level of one sample under the current range
  function automatic logic [rtbn_pkg::ByteBits-1:0] grey_level(
    logic signed [PixBits-1:0] px);
    longint          lo, hi, v;
    longint unsigned span, offs;
    lo = range_lo;
    hi = range_hi;
    v  = px;
    if (hi <= lo) return '0;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    span = hi - lo;
    offs = v - lo;
    // wide ranges truncate, narrow ones round to nearest
    if (span > rtbn_pkg::ByteMax) begin
      return rtbn_pkg::ByteBits'((offs << rtbn_pkg::ByteBits) / (span + 1));
    end
    return rtbn_pkg::ByteBits'((2 * offs * rtbn_pkg::ByteMax + span) / (2 * span));
  endfunction

  // pixel word plus the padding that closes a row
  function automatic void predict_words(logic signed [PixBits-1:0] px);
    int unsigned eff_width, col_next, npad;
    out_word_t   w;
    eff_width = (row_width_q == 0) ? 1 : row_width_q;
    col_next  = cols_taken + 1;
    npad      = 0;
    if (col_next >= eff_width) begin
      cols_taken = 0;
      npad = (4 - eff_width % 4) % 4;
    end else begin
      cols_taken = col_next & ((1 << rtbn_pkg::DefColumnBits) - 1);
    end
    w.grey = grey_level(px);
    w.pad  = 1'b0;
    w.last = (npad == 0);
    grey_words_due.push_back(w);
    for (int k = 0; k < npad; k++) begin
      w.grey = '0;
      w.pad  = 1'b1;
      w.last = (k == npad - 1);
      grey_words_due.push_back(w);
    end
  endfunction

  // sample pick: full random, around the range, extremes, range ends
  function automatic logic [PixBits-1:0] pick_pixel();
    longint base, span;
    base = (range_lo < range_hi) ? range_lo : range_hi;
    span = (range_lo < range_hi) ? range_hi - range_lo : range_lo - range_hi;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return PixBits'(base - 2 + longint'($urandom) % (span + 5));
      8: begin
        case ($urandom_range(3))
          0: return PixMin;
          1: return PixMax;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(1) ? range_lo : range_hi;
    endcase
  endfunction

  // input side: accept on the rising edge, predict at once
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_words(in_pixel_value);
  end

  // sender: next word on the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_pixel_value <= pixel_q.pop_front();
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // result check against the oldest expected word
  always @(posedge clk) begin
    out_word_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (grey_words_due.size() == 0) begin
        $error("unexpected word: out_byte %0d, is_padding %0d, last_of_run %0d",
               out_byte, out_is_padding, out_last_of_run);
        errors++;
      end else begin
        due = grey_words_due.pop_front();
        if (out_byte !== due.grey) begin
          $error("out_byte: expected %0d, got %0d", due.grey, out_byte);
          errors++;
        end
        if (out_is_padding !== due.pad) begin
          $error("is_padding: expected %0d, got %0d", due.pad, out_is_padding);
          errors++;
        end
        if (out_last_of_run !== due.last) begin
          $error("last_of_run: expected %0d, got %0d", due.last, out_last_of_run);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [rtbn_pkg::CfgIdxBits-1:0] idx,
                           logic [rtbn_pkg::CfgBits-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rtbn_pkg::CFG_RANGE_MIN: range_lo = data;
      rtbn_pkg::CFG_RANGE_MAX: range_hi = data;
      rtbn_pkg::CFG_ROW_WIDTH: row_width_q = data[rtbn_pkg::RowBits-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ranges(logic [rtbn_pkg::CfgBits-1:0] lo,
                            logic [rtbn_pkg::CfgBits-1:0] hi,
                            logic [rtbn_pkg::CfgBits-1:0] width);
    write_reg(rtbn_pkg::CFG_RANGE_MIN, lo);
    write_reg(rtbn_pkg::CFG_RANGE_MAX, hi);
    write_reg(rtbn_pkg::CFG_ROW_WIDTH, width);
  endtask

  // idle until every queued word is in and every expected word is out
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || in_valid || grey_words_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 72; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 72; end
      default: begin in_idle_pct = 37; out_stall_pct = 37; end
    endcase
  endtask

  // random range and row width, with inverted and wide ranges in the mix
  task automatic pick_settings();
    logic [rtbn_pkg::CfgBits-1:0] lo, hi, width;
    lo = $urandom;
    case ($urandom_range(6))
      0: begin
        lo = rtbn_pkg::CfgBits'($urandom_range(0, 600)) - rtbn_pkg::CfgBits'(300);
        hi = lo + rtbn_pkg::CfgBits'($urandom_range(1, 300));
      end
      1: hi = lo + rtbn_pkg::CfgBits'($urandom_range(1, 300));
      2: hi = $urandom;
      3: hi = lo + rtbn_pkg::CfgBits'($urandom_range(255, 256));
      4: hi = lo - rtbn_pkg::CfgBits'($urandom_range(0, 50));
      5: begin
        lo = PixMin + rtbn_pkg::CfgBits'($urandom_range(0, 3));
        hi = PixMax - rtbn_pkg::CfgBits'($urandom_range(0, 3));
      end
      default: begin
        lo = rtbn_pkg::CfgBits'($urandom_range(0, 20)) - rtbn_pkg::CfgBits'(10);
        hi = lo + rtbn_pkg::CfgBits'($urandom_range(1, 4));
      end
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: width = {16'($urandom), 16'($urandom_range(1, 9))};
      6: width = {16'($urandom), 16'd0};
      7: width = {16'($urandom), 16'($urandom_range(10, 40))};
      8: width = {16'($urandom), 16'hFFFF};
      default: width = $urandom;
    endcase
    set_ranges(lo, hi, width);
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings; a write to the unmapped index must change nothing
    write_reg(CFG_SPARE, PixMax);
    pixel_q.push_back(32'd0);
    pixel_q.push_back(32'd255);
    pixel_q.push_back(32'd128);
    pixel_q.push_back(32'd127);
    pixel_q.push_back(32'd1);
    pixel_q.push_back('1);
    pixel_q.push_back(32'd256);
    pixel_q.push_back(PixMin);
    pixel_q.push_back(PixMax);
    pixel_q.push_back(32'd254);
    wait_drained();

    // widest range, one pixel per row
    set_idle(3);
    set_ranges(PixMin, PixMax, 32'hFFFF_0001);
    pixel_q.push_back(PixMin);
    pixel_q.push_back(PixMax);
    pixel_q.push_back(32'd0);
    pixel_q.push_back('1);
    wait_drained();

    // symmetric narrow range, zero row width with junk in the upper half
    set_idle(2);
    set_ranges(-32'sd100, 32'sd100, 32'h0001_0000);
    pixel_q.push_back(-32'sd101);
    pixel_q.push_back(-32'sd100);
    pixel_q.push_back(32'd0);
    pixel_q.push_back(32'd100);
    pixel_q.push_back(32'd101);
    wait_drained();

    // empty range
    set_idle(1);
    set_ranges(32'd5, 32'd5, 32'd3);
    pixel_q.push_back(32'd5);
    pixel_q.push_back(32'd4);
    wait_drained();

    // inverted range, longest row
    set_ranges(32'd1000, -32'sd1000, 32'hFFFF);
    pixel_q.push_back(32'd0);
    wait_drained();

    // span of 256, then the row width shrinks mid row
    set_idle(0);
    set_ranges('1, 32'd255, 32'd10);
    pixel_q.push_back('1);
    pixel_q.push_back(32'd255);
    pixel_q.push_back(32'd64);
    wait_drained();
    write_reg(rtbn_pkg::CFG_ROW_WIDTH, 32'd2);
    pixel_q.push_back(32'd100);
    wait_drained();

    // random phases
    for (int ph = 0; ph < RandPhases; ph++) begin
      set_idle(ph % 4);
      pick_settings();
      // long receiver hold-off while the sender keeps offering
      if (ph == 6) begin
        in_idle_pct = 0;
        hold_req    = hold_req + 1;
      end
      for (int i = 0; i < PhaseWords; i++) begin
        // sender pauses until every expected word is out
        if (ph == 9 && i == PhaseWords / 2) wait_drained();
        pixel_q.push_back(pick_pixel());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && grey_words_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
